>>> design/assert_macros.svh
// Assertion macros shared by the escape decoder RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define SEUD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define SEUD_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/seud_pkg.sv
// Package of the string escape decoder: parser modes, command words, character codes.
// No dependencies; the parser, queue, emitter and core files import it.
`default_nettype none

package seud_pkg;

    // Depth of the command queue between the parser and the UTF-8 emitter.
    localparam int unsigned CMD_FIFO_DEPTH = 2;

    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_HEX  = 2'd2
    } mode_t;

    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_UTF8 = 1'b1
    } cmd_kind_t;

    // One command from the parser: a plain byte (value[7:0]) or a code point to encode.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] value;
        logic        last;
        logic        err;
    } cmd_t;

    // Characters of interest.
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_U_LO   = 8'h75;
    localparam logic [7:0] CH_U_UP   = 8'h55;

    // Control codes produced by the simple escapes.
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_VT  = 8'h0B;
    localparam logic [7:0] CTL_BEL = 8'h07;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_HT  = 8'h09;

    // Digit counts of the hex escapes.
    localparam logic [3:0] DIGITS_X  = 4'd2;
    localparam logic [3:0] DIGITS_U  = 4'd4;
    localparam logic [3:0] DIGITS_UU = 4'd8;

    // UTF-8 length thresholds and lead bytes (original six-byte form).
    localparam logic [31:0] LIM_2 = 32'h0000_0080;
    localparam logic [31:0] LIM_3 = 32'h0000_0800;
    localparam logic [31:0] LIM_4 = 32'h0001_0000;
    localparam logic [31:0] LIM_5 = 32'h0020_0000;
    localparam logic [31:0] LIM_6 = 32'h0400_0000;
    localparam logic [7:0]  LEAD_2 = 8'hC0;
    localparam logic [7:0]  LEAD_3 = 8'hE0;
    localparam logic [7:0]  LEAD_4 = 8'hF0;
    localparam logic [7:0]  LEAD_5 = 8'hF8;
    localparam logic [7:0]  LEAD_6 = 8'hFC;
    localparam logic [7:0]  CONT_MARK = 8'h80;
    localparam logic [5:0]  CONT_MASK = 6'h3F;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) ||
               (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    // Digit value; only meaningful when is_hex holds.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        if (c <= 8'h39)
        begin
            v = c[3:0];
        end
        else
        begin
            v = 4'(c[3:0] + 4'd9);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> design/seud_in_if.sv
// Input channel of the escape decoder: one literal byte and its end-of-string flag.
// Stand-alone; no package needed.
`default_nettype none

interface seud_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

>>> design/seud_out_if.sv
// Output channel of the escape decoder: one decoded byte with last and error marks.
// Stand-alone; no package needed.
`default_nettype none

interface seud_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_last;
    logic       bad_escape;

    modport source (output valid, output out_byte, output is_last, output bad_escape,
                    input ready);
    modport sink   (input valid, input out_byte, input is_last, input bad_escape,
                    output ready);
endinterface

`default_nettype wire

>>> design/seud_front.sv
// Parser front end: accepts literal bytes, tracks escape state, issues commands.
// Depends on seud_pkg, seud_in_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module seud_front
    import seud_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    seud_in_if.sink    in_ch,
    output cmd_t       cmd,
    output logic       cmd_valid,
    input  wire logic  cmd_ready
);

    mode_t       mode_reg, mode_next;
    logic [3:0]  digits_left_reg, digits_left_next;
    logic [31:0] code_value_reg, code_value_next;
    logic        fault_seen_reg, fault_seen_next;

    logic        accept;
    logic        emit;
    logic [7:0]  c;
    logic        last;
    logic [31:0] code_shift;
    logic [3:0]  digits_dec;

    assign in_ch.ready = cmd_ready;
    assign accept      = in_ch.valid && cmd_ready;
    assign cmd_valid   = accept && emit;
    assign c           = in_ch.in_byte;
    assign last        = in_ch.end_of_string;
    assign code_shift  = {code_value_reg[27:0], hex_val(c)};
    assign digits_dec  = digits_left_reg - 4'd1;

    always_comb
    begin
        mode_next        = mode_reg;
        digits_left_next = digits_left_reg;
        code_value_next  = code_value_reg;
        fault_seen_next  = fault_seen_reg;
        emit             = 1'b0;
        cmd.kind         = CMD_BYTE;
        cmd.value        = {24'd0, c};
        cmd.last         = last;
        cmd.err          = 1'b0;

        if (fault_seen_reg)
        begin
            // Drop everything until the final byte, then report once.
            if (last)
            begin
                emit      = 1'b1;
                cmd.value = 32'd0;
                cmd.err   = 1'b1;
            end
        end
        else
        begin
            case (mode_reg)
                MODE_ESC:
                begin
                    mode_next = MODE_TEXT;
                    emit      = 1'b1;
                    case (c)
                        CH_N:    cmd.value = {24'd0, CTL_LF};
                        CH_R:    cmd.value = {24'd0, CTL_CR};
                        CH_B:    cmd.value = {24'd0, CTL_BS};
                        CH_V:    cmd.value = {24'd0, CTL_VT};
                        CH_A:    cmd.value = {24'd0, CTL_BEL};
                        CH_F:    cmd.value = {24'd0, CTL_FF};
                        CH_T:    cmd.value = {24'd0, CTL_HT};
                        CH_X, CH_U_LO, CH_U_UP:
                        begin
                            if (last)
                            begin
                                cmd.value = 32'd0;
                                cmd.err   = 1'b1;
                            end
                            else
                            begin
                                emit            = 1'b0;
                                mode_next       = MODE_HEX;
                                code_value_next = 32'd0;
                                if (c == CH_X)
                                begin
                                    digits_left_next = DIGITS_X;
                                end
                                else if (c == CH_U_LO)
                                begin
                                    digits_left_next = DIGITS_U;
                                end
                                else
                                begin
                                    digits_left_next = DIGITS_UU;
                                end
                            end
                        end
                        default: cmd.value = {24'd0, c};
                    endcase
                end

                MODE_HEX:
                begin
                    if (!is_hex(c))
                    begin
                        if (last)
                        begin
                            emit      = 1'b1;
                            cmd.value = 32'd0;
                            cmd.err   = 1'b1;
                        end
                        else
                        begin
                            fault_seen_next = 1'b1;
                        end
                        mode_next        = MODE_TEXT;
                        digits_left_next = 4'd0;
                        code_value_next  = 32'd0;
                    end
                    else if (digits_dec == 4'd0)
                    begin
                        emit             = 1'b1;
                        cmd.kind         = CMD_UTF8;
                        cmd.value        = code_shift;
                        mode_next        = MODE_TEXT;
                        digits_left_next = 4'd0;
                        code_value_next  = 32'd0;
                    end
                    else if (last)
                    begin
                        // The string ended before all digits arrived.
                        emit      = 1'b1;
                        cmd.value = 32'd0;
                        cmd.err   = 1'b1;
                    end
                    else
                    begin
                        code_value_next  = code_shift;
                        digits_left_next = digits_dec;
                    end
                end

                default:
                begin
                    if (c == CH_BSLASH && !last)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        mode_next = MODE_TEXT;
                        emit      = 1'b1;
                    end
                end
            endcase
        end

        // The final byte always returns the parser to its reset state.
        if (last)
        begin
            mode_next        = MODE_TEXT;
            digits_left_next = 4'd0;
            code_value_next  = 32'd0;
            fault_seen_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_TEXT;
            digits_left_reg <= 4'd0;
            code_value_reg  <= 32'd0;
            fault_seen_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg        <= mode_next;
            digits_left_reg <= digits_left_next;
            code_value_reg  <= code_value_next;
            fault_seen_reg  <= fault_seen_next;
        end
    end

    `SEUD_ASSERT(a_fault_clears_escape, fault_seen_reg |-> (mode_reg == MODE_TEXT && digits_left_reg == 4'd0), "fault left escape state behind")
    `SEUD_ASSERT(a_hex_has_digits, (mode_reg == MODE_HEX) |-> (digits_left_reg != 4'd0), "hex mode with no digits left")

endmodule

`default_nettype wire

>>> design/seud_cmd_fifo.sv
// Short command queue between the parser and the UTF-8 emitter.
// Depends on seud_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module seud_cmd_fifo
    import seud_pkg::*;
#(
    parameter int unsigned DEPTH = CMD_FIFO_DEPTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push_valid,
    output logic       push_ready,
    input  wire cmd_t  push_data,
    output logic       pop_valid,
    input  wire logic  pop_ready,
    output cmd_t       pop_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    cmd_t            mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            push, pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= next_ptr(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= next_ptr(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= CW'(count_reg + 1'b1);
            end
            else if (pop && !push)
            begin
                count_reg <= CW'(count_reg - 1'b1);
            end
        end
    end

    `SEUD_ASSERT(a_fifo_count_range, count_reg <= CW'(DEPTH), "command queue overfilled")

endmodule

`default_nettype wire

>>> design/seud_back.sv
// Back end: turns commands into output bytes, expanding code points into UTF-8.
// Depends on seud_pkg, seud_out_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module seud_back
    import seud_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cmd_t  cmd,
    input  wire logic  cmd_valid,
    output logic       cmd_ready,
    seud_out_if.source out_ch
);

    // Output register.
    logic        ov_reg, ov_next;
    logic [7:0]  ob_reg, ob_next;
    logic        ol_reg, ol_next;
    logic        oe_reg, oe_next;

    // Continuation bytes still owed, next group at the top of rem_reg.
    logic [31:0] rem_reg, rem_next;
    logic [2:0]  rem_cnt_reg, rem_cnt_next;
    logic        rem_last_reg, rem_last_next;

    logic        load;
    logic [7:0]  lead;
    logic [31:0] cont_rem;
    logic [2:0]  cont_cnt;
    logic [31:0] w;

    assign w = cmd.value;

    // Lead byte and left-aligned continuation groups for the sequence length.
    always_comb
    begin
        if (w < LIM_2)
        begin
            lead     = w[7:0];
            cont_rem = 32'd0;
            cont_cnt = 3'd0;
        end
        else if (w < LIM_3)
        begin
            lead     = 8'(w >> 6) | LEAD_2;
            cont_rem = w << 26;
            cont_cnt = 3'd1;
        end
        else if (w < LIM_4)
        begin
            lead     = 8'(w >> 12) | LEAD_3;
            cont_rem = w << 20;
            cont_cnt = 3'd2;
        end
        else if (w < LIM_5)
        begin
            lead     = 8'(w >> 18) | LEAD_4;
            cont_rem = w << 14;
            cont_cnt = 3'd3;
        end
        else if (w < LIM_6)
        begin
            lead     = 8'(w >> 24) | LEAD_5;
            cont_rem = w << 8;
            cont_cnt = 3'd4;
        end
        else
        begin
            lead     = 8'(w >> 30) | LEAD_6;
            cont_rem = w << 2;
            cont_cnt = 3'd5;
        end
    end

    assign load      = !ov_reg || out_ch.ready;
    assign cmd_ready = load && (rem_cnt_reg == 3'd0);

    always_comb
    begin
        ov_next       = ov_reg;
        ob_next       = ob_reg;
        ol_next       = ol_reg;
        oe_next       = oe_reg;
        rem_next      = rem_reg;
        rem_cnt_next  = rem_cnt_reg;
        rem_last_next = rem_last_reg;

        if (load)
        begin
            if (rem_cnt_reg != 3'd0)
            begin
                ov_next      = 1'b1;
                ob_next      = CONT_MARK | {2'b00, rem_reg[31:26] & CONT_MASK};
                ol_next      = rem_last_reg && (rem_cnt_reg == 3'd1);
                oe_next      = 1'b0;
                rem_next     = rem_reg << 6;
                rem_cnt_next = 3'(rem_cnt_reg - 3'd1);
            end
            else if (cmd_valid)
            begin
                ov_next = 1'b1;
                if (cmd.kind == CMD_BYTE)
                begin
                    ob_next = cmd.value[7:0];
                    ol_next = cmd.last;
                    oe_next = cmd.err;
                end
                else
                begin
                    ob_next       = lead;
                    ol_next       = cmd.last && (cont_cnt == 3'd0);
                    oe_next       = 1'b0;
                    rem_next      = cont_rem;
                    rem_cnt_next  = cont_cnt;
                    rem_last_next = cmd.last;
                end
            end
            else
            begin
                ov_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg      <= 1'b0;
            rem_cnt_reg <= 3'd0;
        end
        else
        begin
            ov_reg      <= ov_next;
            rem_cnt_reg <= rem_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ob_reg       <= ob_next;
        ol_reg       <= ol_next;
        oe_reg       <= oe_next;
        rem_reg      <= rem_next;
        rem_last_reg <= rem_last_next;
    end

    assign out_ch.valid      = ov_reg;
    assign out_ch.out_byte   = ob_reg;
    assign out_ch.is_last    = ol_reg;
    assign out_ch.bad_escape = oe_reg;

    `SEUD_ASSERT(a_error_is_final_zero, (ov_reg && oe_reg) |-> (ol_reg && ob_reg == 8'd0), "error word not final or not zero")
    `SEUD_ASSERT(a_cont_count_range, rem_cnt_reg <= 3'd5, "too many continuation bytes pending")

endmodule

`default_nettype wire

>>> design/string_escape_utf8_decoder_core.sv
// String escape decoder. Takes the body of a string literal one word per cycle
// while the command queue has room, the final byte flagged by end_of_string,
// and gives the decoded bytes one word per cycle while the receiver is ready.
// Simple escapes (n r b v a f t) become control codes, other escaped bytes pass
// as themselves, and \x, \u, \U collect 2, 4 or 8 hex digits whose value leaves
// as a UTF-8 sequence of 1 to 6 bytes in the original long form. A malformed or
// unfinished hex escape yields one word at the end of the string with out_byte
// zero and both is_last and bad_escape set; bytes that were emitted before the
// fault stand. The input stalls only when the command queue (FIFO_DEPTH
// entries) is full, which happens while a hex escape that expands to more than
// one byte holds the emitter or the receiver holds off; the queue absorbs
// following input meanwhile. The parser decides combinationally and writes its
// command into the queue when the word is accepted, and the emitter loads the
// output register from the queue once that register is free.
`default_nettype none

module string_escape_utf8_decoder_core
    import seud_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = CMD_FIFO_DEPTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    seud_in_if.sink    in_ch,
    seud_out_if.source out_ch
);

    // Commands from the parser into the queue.
    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;

    // Commands from the queue into the emitter.
    cmd_t back_cmd;
    logic back_valid;
    logic back_ready;

    // The parser keeps all escape state and issues at most one command per
    // input word: a literal byte, an error marker, or a code point to encode.
    seud_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    // The queue decouples the two halves so the parser keeps taking input
    // while a multi-byte sequence drains.
    seud_cmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_cmd)
    );

    // The emitter writes one byte per cycle into its output register while the
    // receiver is ready, and walks through the continuation bytes of a UTF-8 sequence.
    seud_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire

>>> tb/sv/string_escape_utf8_decoder_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the string escape decoder core: directed rows, then random strings.
// Depends on seud_pkg and the seud_in_if / seud_out_if channel interfaces of the design.

module string_escape_utf8_decoder_core_test;
    import seud_pkg::*;

    // One decoded word as it leaves the block.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } dec_word_t;

    // One row of the directed stimulus. When typed is set, the row causes exactly the
    // single word in want; otherwise the expected words come from the predictor.
    typedef struct packed {
        logic [7:0] data;
        logic       eos;
        logic       typed;
        dec_word_t  want;
    } stim_row_t;

    localparam dec_word_t   ERROR_WORD   = '{8'h00, 1'b1, 1'b1};
    localparam dec_word_t   NO_WORD      = '{8'h00, 1'b0, 1'b0};
    localparam int unsigned ITEM_TARGET  = 430;
    localparam int unsigned MAX_GAP      = 16;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned REPORT_LIMIT = 10;
    // Bound on the run; it sits well above the slowest legal run, long hold included.
    localparam int unsigned CYCLE_LIMIT  = 400_000;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_G      = 8'h67;
    localparam logic [7:0] CH_Q      = 8'h51;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_F_UP   = 8'h46;

    // The directed part: extremes of the byte, a simple escape, a quote escape as the
    // final byte, a backslash as the final byte, a hex escape opened on the final byte,
    // a bad digit followed by dropped bytes, a string ending before all digits arrive,
    // and the largest code point, which needs the six-byte form.
    localparam stim_row_t DIRECTED_ROWS [27] = '{
        '{8'h00,     1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{8'hFF,     1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0}},
        '{CH_BSLASH, 1'b0, 1'b0, NO_WORD},
        '{CH_N,      1'b0, 1'b1, '{CTL_LF, 1'b0, 1'b0}},
        '{CH_BSLASH, 1'b0, 1'b0, NO_WORD},
        '{CH_DQUOTE, 1'b1, 1'b1, '{CH_DQUOTE, 1'b1, 1'b0}},
        '{CH_BSLASH, 1'b1, 1'b1, '{CH_BSLASH, 1'b1, 1'b0}},
        '{CH_BSLASH, 1'b0, 1'b0, NO_WORD},
        '{CH_X,      1'b1, 1'b1, ERROR_WORD},
        '{CH_BSLASH, 1'b0, 1'b0, NO_WORD},
        '{CH_X,      1'b0, 1'b0, NO_WORD},
        '{CH_G,      1'b0, 1'b0, NO_WORD},
        '{CH_BSLASH, 1'b0, 1'b0, NO_WORD},
        '{CH_Q,      1'b1, 1'b1, ERROR_WORD},
        '{CH_BSLASH, 1'b0, 1'b0, NO_WORD},
        '{CH_U_LO,   1'b0, 1'b0, NO_WORD},
        '{CH_ONE,    1'b1, 1'b1, ERROR_WORD},
        '{CH_BSLASH, 1'b0, 1'b0, NO_WORD},
        '{CH_U_UP,   1'b0, 1'b0, NO_WORD},
        '{CH_F_UP,   1'b0, 1'b0, NO_WORD},
        '{CH_F_UP,   1'b0, 1'b0, NO_WORD},
        '{CH_F_UP,   1'b0, 1'b0, NO_WORD},
        '{CH_F_UP,   1'b0, 1'b0, NO_WORD},
        '{CH_F_UP,   1'b0, 1'b0, NO_WORD},
        '{CH_F_UP,   1'b0, 1'b0, NO_WORD},
        '{CH_F_UP,   1'b0, 1'b0, NO_WORD},
        '{CH_F_UP,   1'b1, 1'b0, NO_WORD}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    seud_in_if  in_ch ();
    seud_out_if out_ch ();

    string_escape_utf8_decoder_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Decoder state mirrored by the predictor.
    mode_t       dec_mode;
    logic [3:0]  digits_pending;
    logic [31:0] hex_acc;
    logic        escape_fault;

    dec_word_t   expected_words [$];
    int unsigned mismatch_count = 0;
    int unsigned words_sent     = 0;
    int unsigned cycle_count    = 0;
    bit          timed_out      = 1'b0;
    bit          sender_calm    = 1'b0;
    bit          long_hold_due  = 1'b0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------
    // Queue helpers
    // ------------------------------------------------------------------

    // Appends one word at the back of a word queue.
    function automatic void add_word(ref dec_word_t words [$], input dec_word_t w);
        words.insert(words.size(), w);
    endfunction

    // Appends one byte at the back of a string under construction.
    function automatic void add_char(ref logic [7:0] s [$], input logic [7:0] b);
        s.insert(s.size(), b);
    endfunction

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_decoder();
        dec_mode       = MODE_TEXT;
        digits_pending = 4'd0;
        hex_acc        = 32'd0;
        escape_fault   = 1'b0;
    endfunction

    // Returns {valid, value} for an ASCII hex digit of either case.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return {1'b1, c[3:0]};
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            return {1'b1, 4'(c - 8'h57)};
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            return {1'b1, 4'(c - 8'h37)};
        end
        return 5'd0;
    endfunction

    // Long-form UTF-8: the lead byte carries the length, every following byte six bits.
    // Values from 0x80000000 up still use six bytes, the lead truncated to eight bits.
    function automatic void encode_utf8(input logic [31:0] w, input logic eos,
                                        ref dec_word_t words [$]);
        int unsigned n;
        logic [7:0]  lead;
        if (w < LIM_2)
        begin
            n = 1;
            lead = w[7:0];
        end
        else if (w < LIM_3)
        begin
            n = 2;
            lead = 8'(w >> 6) | LEAD_2;
        end
        else if (w < LIM_4)
        begin
            n = 3;
            lead = 8'(w >> 12) | LEAD_3;
        end
        else if (w < LIM_5)
        begin
            n = 4;
            lead = 8'(w >> 18) | LEAD_4;
        end
        else if (w < LIM_6)
        begin
            n = 5;
            lead = 8'(w >> 24) | LEAD_5;
        end
        else
        begin
            n = 6;
            lead = 8'(w >> 30) | LEAD_6;
        end
        add_word(words, '{lead, (n == 1) ? eos : 1'b0, 1'b0});
        for (int i = 1; i < n; i++)
        begin
            add_word(words, '{CONT_MARK | {2'b00, 6'(w >> (6 * (n - 1 - i)))},
                              (i == n - 1) ? eos : 1'b0, 1'b0});
        end
    endfunction

    // Works out the words that one accepted input byte causes and advances the state.
    function automatic void decode_byte(input logic [7:0] c, input logic eos,
                                        ref dec_word_t words [$]);
        logic [7:0]  esc;
        logic [4:0]  digit;
        logic [31:0] value;
        logic        opens_hex;
        words.delete();
        // After a malformed escape everything up to the final byte is swallowed.
        if (escape_fault)
        begin
            if (eos)
            begin
                add_word(words, ERROR_WORD);
                clear_decoder();
            end
            return;
        end
        case (dec_mode)
            MODE_ESC:
            begin
                esc = c;
                opens_hex = 1'b0;
                case (c)
                    CH_N:    esc = CTL_LF;
                    CH_R:    esc = CTL_CR;
                    CH_B:    esc = CTL_BS;
                    CH_V:    esc = CTL_VT;
                    CH_A:    esc = CTL_BEL;
                    CH_F:    esc = CTL_FF;
                    CH_T:    esc = CTL_HT;
                    CH_X, CH_U_LO, CH_U_UP: opens_hex = 1'b1;
                    default: esc = c;
                endcase
                if (opens_hex && eos)
                begin
                    add_word(words, ERROR_WORD);
                    clear_decoder();
                end
                else if (opens_hex)
                begin
                    dec_mode = MODE_HEX;
                    digits_pending = (c == CH_X) ? DIGITS_X :
                                     (c == CH_U_LO) ? DIGITS_U : DIGITS_UU;
                    hex_acc = 32'd0;
                end
                else
                begin
                    dec_mode = MODE_TEXT;
                    add_word(words, '{esc, eos, 1'b0});
                    if (eos)
                    begin
                        clear_decoder();
                    end
                end
            end
            MODE_HEX:
            begin
                digit = hex_digit(c);
                if (!digit[4] && eos)
                begin
                    add_word(words, ERROR_WORD);
                    clear_decoder();
                end
                else if (!digit[4])
                begin
                    escape_fault = 1'b1;
                    dec_mode = MODE_TEXT;
                    digits_pending = 4'd0;
                    hex_acc = 32'd0;
                end
                else
                begin
                    hex_acc = {hex_acc[27:0], digit[3:0]};
                    digits_pending = digits_pending - 4'd1;
                    if (digits_pending == 4'd0)
                    begin
                        value = hex_acc;
                        dec_mode = MODE_TEXT;
                        hex_acc = 32'd0;
                        encode_utf8(value, eos, words);
                        if (eos)
                        begin
                            clear_decoder();
                        end
                    end
                    else if (eos)
                    begin
                        // The string ran out before the escape had all its digits.
                        add_word(words, ERROR_WORD);
                        clear_decoder();
                    end
                end
            end
            default:
            begin
                // A backslash only opens an escape when more bytes follow it.
                if (c == CH_BSLASH && !eos)
                begin
                    dec_mode = MODE_ESC;
                end
                else
                begin
                    dec_mode = MODE_TEXT;
                    add_word(words, '{c, eos, 1'b0});
                    if (eos)
                    begin
                        clear_decoder();
                    end
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Random string builder
    // ------------------------------------------------------------------

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
        begin
            return 8'h30 + 8'(v);
        end
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        logic [4:0] digit;
        do
        begin
            c = 8'($urandom_range(0, 255));
            digit = hex_digit(c);
        end
        while (digit[4]);
        return c;
    endfunction

    // Builds the bytes of one literal. Most escapes are well formed with random
    // content; a few carry a bad digit or cut the string short.
    function automatic void build_string(ref logic [7:0] s [$]);
        int unsigned tokens;
        int unsigned pick;
        int unsigned need;
        int unsigned zeros;
        int unsigned got;
        logic [7:0]  opener;
        logic [7:0]  simple [10];
        simple = '{CH_N, CH_R, CH_B, CH_V, CH_A, CH_F, CH_T, CH_BSLASH, CH_DQUOTE, CH_SQUOTE};
        s.delete();
        tokens = $urandom_range(1, 6);
        for (int t = 0; t < tokens; t++)
        begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 2))
                0:       begin opener = CH_X;    need = DIGITS_X;  end
                1:       begin opener = CH_U_LO; need = DIGITS_U;  end
                default: begin opener = CH_U_UP; need = DIGITS_UU; end
            endcase
            if (pick < 30)
            begin
                add_char(s, 8'($urandom_range(0, 255)));
            end
            else if (pick < 45)
            begin
                add_char(s, CH_BSLASH);
                add_char(s, simple[$urandom_range(0, 9)]);
            end
            else if (pick < 52)
            begin
                add_char(s, CH_BSLASH);
                add_char(s, 8'($urandom_range(0, 255)));
            end
            else if (pick < 85)
            begin
                // Leading zeros spread the code points over all encoded lengths.
                zeros = $urandom_range(0, need);
                add_char(s, CH_BSLASH);
                add_char(s, opener);
                for (int d = 0; d < need; d++)
                begin
                    add_char(s, hex_char((d < zeros) ? 4'd0 : 4'($urandom_range(0, 15))));
                end
            end
            else
            begin
                got = $urandom_range(0, need - 1);
                add_char(s, CH_BSLASH);
                add_char(s, opener);
                for (int d = 0; d < got; d++)
                begin
                    add_char(s, hex_char(4'($urandom_range(0, 15))));
                end
                if (pick < 93)
                begin
                    add_char(s, non_hex_char());
                end
                else
                begin
                    return;
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offers one word after a random gap (none while the sender is calm), waits for
    // the handshake and records what the block has to produce for it.
    task automatic send_word(input stim_row_t row);
        int unsigned gap;
        dec_word_t   fresh [$];
        gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.in_byte       <= row.data;
        in_ch.end_of_string <= row.eos;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        words_sent++;
        decode_byte(row.data, row.eos, fresh);
        if (row.typed)
        begin
            add_word(expected_words, row.want);
        end
        else
        begin
            foreach (fresh[i])
            begin
                add_word(expected_words, fresh[i]);
            end
        end
    endtask

    task automatic run_stimulus();
        logic [7:0] text [$];
        for (int r = 0; r < $size(DIRECTED_ROWS); r++)
        begin
            send_word(DIRECTED_ROWS[r]);
        end
        // The receiver holds off once, long enough for the command queue to fill
        // and the block to push back on the input.
        long_hold_due = 1'b1;
        while (words_sent < ITEM_TARGET)
        begin
            build_string(text);
            sender_calm = ($urandom_range(0, 3) == 0);
            foreach (text[i])
            begin
                send_word('{text[i], (i == text.size() - 1), 1'b0, NO_WORD});
            end
        end
        in_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string why, input dec_word_t want, input dec_word_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("[%0t] %s: expected byte %02h last %0b err %0b, got byte %02h last %0b err %0b",
                     $realtime, why, want.data, want.last, want.err,
                     got.data, got.last, got.err);
        end
    endtask

    // The receiver draws a stall before every word, with calm stretches where it
    // takes every word at once, and one long hold early in the random part.
    initial
    begin
        int unsigned gap;
        bit          drain_calm;
        drain_calm = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (long_hold_due)
            begin
                long_hold_due = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                if ($urandom_range(0, 31) == 0)
                begin
                    drain_calm = !drain_calm;
                end
                gap = drain_calm ? 0 : $urandom_range(0, MAX_GAP);
                if (gap > 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ch.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!out_ch.valid);
        end
    end

    // Every accepted word is checked against the oldest expectation.
    always @(posedge clk)
    begin
        dec_word_t got;
        dec_word_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.out_byte, out_ch.is_last, out_ch.bad_escape};
            if (expected_words.size() == 0)
            begin
                note_mismatch("unexpected word", NO_WORD, got);
            end
            else
            begin
                want = expected_words.pop_front();
                if (got.data !== want.data || got.last !== want.last || got.err !== want.err)
                begin
                    note_mismatch("word mismatch", want, got);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        in_ch.valid         <= 1'b0;
        in_ch.in_byte       <= 8'h00;
        in_ch.end_of_string <= 1'b0;
        clear_decoder();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        fork
            begin
                run_stimulus();
                while (expected_words.size() != 0)
                begin
                    @(posedge clk);
                end
                // Give a stray extra word time to show up.
                repeat (DRAIN_CYCLES) @(posedge clk);
            end
            begin
                while (cycle_count < CYCLE_LIMIT)
                begin
                    @(posedge clk);
                end
                timed_out = 1'b1;
            end
        join_any
        disable fork;

        if (expected_words.size() != 0)
        begin
            $display("%0d expected words never arrived", expected_words.size());
            mismatch_count += expected_words.size();
        end
        if (!timed_out && mismatch_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
